[src/assert_macros.svh]
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BPR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BPR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BPR_ASSERT(lbl, clk, rst, prop, msg)
`define BPR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[src/bpr_pkg.sv]
package bpr_pkg;

   // request opcodes
   localparam logic [2:0] OP_PIN        = 3'd0;
   localparam logic [2:0] OP_UNPIN      = 3'd1;
   localparam logic [2:0] OP_MARK_DIRTY = 3'd2;
   localparam logic [2:0] OP_FORCE      = 3'd3;
   localparam logic [2:0] OP_FLUSH      = 3'd4;

   // replacement policies
   localparam logic [1:0] POL_FIFO  = 2'd0;
   localparam logic [1:0] POL_LRU   = 2'd1;
   localparam logic [1:0] POL_CLOCK = 2'd2;
   localparam logic [1:0] POL_LFU   = 2'd3;

   // response status codes
   localparam logic [1:0] RS_OK         = 2'd0;
   localparam logic [1:0] RS_NOT_FOUND  = 2'd1;
   localparam logic [1:0] RS_ALL_PINNED = 2'd2;

   // flush words per request
   localparam int MAX_RESULTS = 8;
   localparam int CNT_W       = 4;

   localparam logic [7:0]  PINS_MAX = 8'hFF;
   localparam logic [15:0] USES_MAX = 16'hFFFF;
   localparam logic [31:0] CNT_MAX  = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_VICTIM,
      S_ACT,
      S_DONE,
      S_FLUSH_COUNT,
      S_FLUSH_EMIT
   } state_type;

   typedef struct packed {
      logic load_req;
      logic scan_clear;
      logic scan_step;
      logic vic_init;
      logic vic_step;
      logic act;
      logic emit;
      logic emit_blank;
      logic flush_count_step;
      logic flush_emit_step;
   } cmd_type;

   typedef struct packed {
      logic req_is_flush;
      logic scan_last;
      logic need_victim;
      logic vic_done;
      logic flush_zero;
      logic flush_done;
   } stat_type;

   function automatic logic [31:0] sat_inc32(input logic [31:0] v);
      return (v == CNT_MAX) ? v : v + 32'd1;
   endfunction

endpackage

[src/bpr_controller.sv]
`include "assert_macros.svh"

module bpr_controller import bpr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req   = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in = stat.req_is_flush ? S_FLUSH_COUNT : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.need_victim) begin
               cmd.vic_init = 1'b1;
               state_in = S_VICTIM;
            end else begin
               state_in = S_ACT;
            end
         end
         S_VICTIM: begin
            cmd.vic_step = 1'b1;
            if (stat.vic_done) begin
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            cmd.act  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         S_FLUSH_COUNT: begin
            cmd.flush_count_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_FLUSH_EMIT;
            end
         end
         S_FLUSH_EMIT: begin
            if (stat.flush_zero) begin
               cmd.emit_blank = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.flush_emit_step = 1'b1;
               if (stat.flush_done) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   `BPR_ASSERT_NEXT(a_act_then_done, clock, reset, state_ff == S_ACT, state_ff == S_DONE, "act not followed by done")
   `BPR_ASSERT(a_cmd_onehot, clock, reset, $onehot0({cmd.scan_step, cmd.vic_step, cmd.act, cmd.emit, cmd.emit_blank, cmd.flush_count_step, cmd.flush_emit_step}), "conflicting datapath commands")

endmodule

[src/bpr_datapath.sv]
`include "assert_macros.svh"

module bpr_datapath import bpr_pkg::*; #(
   parameter int NUM_FRAMES = 8,
   parameter int PAGE_BITS  = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic [2:0]           req_opcode,
   input  logic [PAGE_BITS-1:0] req_page_number,
   input  logic                 csr_valid,
   input  logic [1:0]           csr_data,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [2:0]           rsp_frame,
   output logic                 rsp_hit,
   output logic                 rsp_read_page,
   output logic                 rsp_write_back,
   output logic [PAGE_BITS-1:0] rsp_write_page,
   output logic [31:0]          rsp_reads_done,
   output logic [31:0]          rsp_writes_done,
   output logic                 rsp_last
);

   localparam int IDX_W = $clog2(NUM_FRAMES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FRAMES - 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_RESULTS);

   function automatic logic [2:0] idx3(input logic [IDX_W-1:0] i);
      logic [IDX_W+2:0] w;
      w = {3'b000, i};
      return w[2:0];
   endfunction

   // request and config
   logic [2:0]           op_ff;
   logic [PAGE_BITS-1:0] pg_ff;
   logic [1:0]           policy_ff;

   // frame table
   logic [PAGE_BITS-1:0] page_ff  [NUM_FRAMES];
   logic [7:0]           pins_ff  [NUM_FRAMES];
   logic [31:0]          stamp_ff [NUM_FRAMES];
   logic [15:0]          uses_ff  [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] valid_ff, dirty_ff, ref_ff;

   // hands and counters
   logic [IDX_W-1:0] fifo_hand_ff, clock_hand_ff, lfu_start_ff;
   logic [31:0]      access_ff, reads_ff, writes_ff;

   // scan trackers
   logic [IDX_W-1:0]     ix_ff, vc_ff;
   logic                 match_found_ff, empty_found_ff, unpinned_ff;
   logic [IDX_W-1:0]     match_ix_ff, empty_ix_ff;
   logic [7:0]           match_pins_ff;
   logic [15:0]          match_uses_ff;
   logic                 vic_found_ff, vic_dirty_ff;
   logic [IDX_W-1:0]     vic_ix_ff;
   logic [31:0]          vic_key_ff;
   logic [PAGE_BITS-1:0] vic_page_ff;
   logic [CNT_W-1:0]     fl_cnt_ff, fl_emit_ff;

   // response word
   logic                 rsp_valid_ff, rsp_hit_ff, rsp_read_ff, rsp_wb_ff, rsp_last_ff;
   logic [1:0]           rsp_status_ff;
   logic [2:0]           rsp_frame_ff;
   logic [PAGE_BITS-1:0] rsp_wp_ff;
   logic [31:0]          rsp_reads_ff, rsp_writes_ff;

   // response fields for the request being acted on
   logic                 rsp_hit_in, rsp_read_in, rsp_wb_in;
   logic [1:0]           rsp_status_in;
   logic [2:0]           rsp_frame_in;
   logic [PAGE_BITS-1:0] rsp_wp_in;

   // current frame at the scan index
   logic                 cur_valid, cur_dirty, cur_ref, cur_unp, cur_match, cur_qual;
   logic [PAGE_BITS-1:0] cur_page;
   logic [31:0]          cur_key, access_inc;
   logic [IDX_W-1:0]     ix_nx, vic_start, fill_ix;
   logic                 scan_all, take_first, better, do_fill, emit_ok;

   assign cur_valid = valid_ff[ix_ff];
   assign cur_dirty = dirty_ff[ix_ff];
   assign cur_ref   = ref_ff[ix_ff];
   assign cur_page  = page_ff[ix_ff];
   assign cur_unp   = (pins_ff[ix_ff] == 8'd0);
   assign cur_match = cur_valid && (cur_page == pg_ff);
   assign cur_qual  = cur_valid && cur_unp && cur_dirty;
   assign cur_key   = (policy_ff == POL_LRU) ? stamp_ff[ix_ff] : {16'd0, uses_ff[ix_ff]};
   assign ix_nx     = (ix_ff == LAST_IDX) ? '0 : ix_ff + 1'b1;
   assign access_inc = sat_inc32(access_ff);

   // victim selection terms
   assign scan_all   = (policy_ff == POL_LRU) || (policy_ff == POL_LFU);
   assign take_first = ((policy_ff == POL_FIFO) && cur_unp)
                    || ((policy_ff == POL_CLOCK) && cur_unp && !cur_ref);
   assign better     = cur_unp && (!vic_found_ff || (cur_key < vic_key_ff));
   assign emit_ok    = cur_qual && (fl_emit_ff < fl_cnt_ff);

   always_comb begin
      case (policy_ff)
         POL_FIFO:  vic_start = fifo_hand_ff;
         POL_CLOCK: vic_start = clock_hand_ff;
         POL_LFU:   vic_start = lfu_start_ff;
         default:   vic_start = '0;
      endcase
   end

   assign fill_ix = empty_found_ff ? empty_ix_ff : vic_ix_ff;
   assign do_fill = (op_ff == OP_PIN) && !match_found_ff && (empty_found_ff || unpinned_ff);

   // status to controller
   always_comb begin
      stat.req_is_flush = (req_opcode == OP_FLUSH);
      stat.scan_last    = (ix_ff == LAST_IDX);
      stat.need_victim  = (op_ff == OP_PIN) && !match_found_ff && !empty_found_ff
                       && unpinned_ff;
      stat.vic_done     = scan_all ? (vc_ff == LAST_IDX) : take_first;
      stat.flush_zero   = (fl_cnt_ff == '0);
      stat.flush_done   = emit_ok && (fl_emit_ff == fl_cnt_ff - 1'b1);
   end

   // policy register
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POL_FIFO;
      end else if (csr_valid) begin
         policy_ff <= csr_data;
      end
   end

   // request latch and page numbers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_opcode;
         pg_ff <= req_page_number;
      end
      if (cmd.act && do_fill) begin
         page_ff[fill_ix] <= pg_ff;
      end
   end

   // frame table control, counters and scan trackers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         dirty_ff       <= '0;
         ref_ff         <= '0;
         for (int i = 0; i < NUM_FRAMES; i++) begin
            pins_ff[i]  <= 8'd0;
            stamp_ff[i] <= 32'd0;
            uses_ff[i]  <= 16'd0;
         end
         fifo_hand_ff   <= '0;
         clock_hand_ff  <= '0;
         lfu_start_ff   <= '0;
         access_ff      <= 32'd0;
         reads_ff       <= 32'd0;
         writes_ff      <= 32'd0;
         ix_ff          <= '0;
         vc_ff          <= '0;
         match_found_ff <= 1'b0;
         empty_found_ff <= 1'b0;
         unpinned_ff    <= 1'b0;
         vic_found_ff   <= 1'b0;
         fl_cnt_ff      <= '0;
         fl_emit_ff     <= '0;
      end else begin
         // start of a request
         if (cmd.scan_clear) begin
            ix_ff          <= '0;
            match_found_ff <= 1'b0;
            empty_found_ff <= 1'b0;
            unpinned_ff    <= 1'b0;
            fl_cnt_ff      <= '0;
            fl_emit_ff     <= '0;
         end
         // lookup pass
         if (cmd.scan_step) begin
            if (cur_match && !match_found_ff) begin
               match_found_ff <= 1'b1;
               match_ix_ff    <= ix_ff;
               match_pins_ff  <= pins_ff[ix_ff];
               match_uses_ff  <= uses_ff[ix_ff];
            end
            if (!cur_valid && !empty_found_ff) begin
               empty_found_ff <= 1'b1;
               empty_ix_ff    <= ix_ff;
            end
            if (cur_unp) begin
               unpinned_ff <= 1'b1;
            end
            ix_ff <= ix_nx;
         end
         // victim pass
         if (cmd.vic_init) begin
            ix_ff        <= vic_start;
            vc_ff        <= '0;
            vic_found_ff <= 1'b0;
         end
         if (cmd.vic_step) begin
            if ((scan_all && better) || (!scan_all && take_first)) begin
               vic_found_ff <= 1'b1;
               vic_ix_ff    <= ix_ff;
               vic_key_ff   <= cur_key;
               vic_dirty_ff <= cur_dirty;
               vic_page_ff  <= cur_page;
            end
            if ((policy_ff == POL_CLOCK) && cur_unp && cur_ref) begin
               ref_ff[ix_ff] <= 1'b0;
            end
            ix_ff <= ix_nx;
            vc_ff <= vc_ff + 1'b1;
         end
         // flush counting pass
         if (cmd.flush_count_step) begin
            if (cur_qual && (fl_cnt_ff < CNT_LIMIT)) begin
               fl_cnt_ff <= fl_cnt_ff + 1'b1;
               writes_ff <= sat_inc32(writes_ff);
            end
            ix_ff <= ix_nx;
         end
         // flush write-out pass
         if (cmd.flush_emit_step) begin
            if (emit_ok) begin
               dirty_ff[ix_ff] <= 1'b0;
               fl_emit_ff      <= fl_emit_ff + 1'b1;
            end
            ix_ff <= ix_nx;
         end
         // table update for the request
         if (cmd.act) begin
            case (op_ff)
               OP_PIN: begin
                  if (match_found_ff) begin
                     if (match_pins_ff != PINS_MAX) begin
                        pins_ff[match_ix_ff] <= match_pins_ff + 8'd1;
                     end
                     access_ff <= access_inc;
                     if (policy_ff == POL_LRU) begin
                        stamp_ff[match_ix_ff] <= access_inc;
                     end else if (policy_ff == POL_CLOCK) begin
                        ref_ff[match_ix_ff] <= 1'b1;
                     end else if ((policy_ff == POL_LFU) && (match_uses_ff != USES_MAX)) begin
                        uses_ff[match_ix_ff] <= match_uses_ff + 16'd1;
                     end
                  end else if (do_fill) begin
                     if (!empty_found_ff) begin
                        if (vic_dirty_ff) begin
                           writes_ff <= sat_inc32(writes_ff);
                        end
                        case (policy_ff)
                           POL_FIFO:  fifo_hand_ff  <= (vic_ix_ff == LAST_IDX) ? '0 : vic_ix_ff + 1'b1;
                           POL_CLOCK: clock_hand_ff <= (vic_ix_ff == LAST_IDX) ? '0 : vic_ix_ff + 1'b1;
                           POL_LFU:   lfu_start_ff  <= (vic_ix_ff == LAST_IDX) ? '0 : vic_ix_ff + 1'b1;
                           default:   ;
                        endcase
                     end
                     access_ff          <= access_inc;
                     reads_ff           <= sat_inc32(reads_ff);
                     valid_ff[fill_ix]  <= 1'b1;
                     dirty_ff[fill_ix]  <= 1'b0;
                     pins_ff[fill_ix]   <= 8'd1;
                     uses_ff[fill_ix]   <= 16'd0;
                     stamp_ff[fill_ix]  <= access_inc;
                     ref_ff[fill_ix]    <= (policy_ff == POL_CLOCK);
                  end
               end
               OP_UNPIN: begin
                  if (match_found_ff && (match_pins_ff != 8'd0)) begin
                     pins_ff[match_ix_ff] <= match_pins_ff - 8'd1;
                  end
               end
               OP_MARK_DIRTY: begin
                  if (match_found_ff) begin
                     dirty_ff[match_ix_ff] <= 1'b1;
                  end
               end
               OP_FORCE: begin
                  if (match_found_ff) begin
                     dirty_ff[match_ix_ff] <= 1'b0;
                     writes_ff <= sat_inc32(writes_ff);
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // response fields for the request
   always_comb begin
      rsp_status_in = RS_OK;
      rsp_frame_in  = 3'd0;
      rsp_hit_in    = 1'b0;
      rsp_read_in   = 1'b0;
      rsp_wb_in     = 1'b0;
      rsp_wp_in     = '0;
      case (op_ff)
         OP_PIN: begin
            if (match_found_ff) begin
               rsp_frame_in = idx3(match_ix_ff);
               rsp_hit_in   = 1'b1;
            end else if (do_fill) begin
               rsp_frame_in = idx3(fill_ix);
               rsp_read_in  = 1'b1;
               if (!empty_found_ff && vic_dirty_ff) begin
                  rsp_wb_in = 1'b1;
                  rsp_wp_in = vic_page_ff;
               end
            end else begin
               rsp_status_in = RS_ALL_PINNED;
            end
         end
         OP_UNPIN: begin
            if (match_found_ff) begin
               rsp_frame_in = idx3(match_ix_ff);
            end
         end
         OP_MARK_DIRTY: begin
            if (match_found_ff) begin
               rsp_frame_in = idx3(match_ix_ff);
            end else begin
               rsp_status_in = RS_NOT_FOUND;
            end
         end
         OP_FORCE: begin
            if (match_found_ff) begin
               rsp_frame_in = idx3(match_ix_ff);
               rsp_wb_in    = 1'b1;
               rsp_wp_in    = pg_ff;
            end
         end
         default: ;
      endcase
   end

   // response word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit || cmd.emit_blank || (cmd.flush_emit_step && emit_ok);
      end
      if (cmd.act) begin
         rsp_status_ff <= rsp_status_in;
         rsp_frame_ff  <= rsp_frame_in;
         rsp_hit_ff    <= rsp_hit_in;
         rsp_read_ff   <= rsp_read_in;
         rsp_wb_ff     <= rsp_wb_in;
         rsp_wp_ff     <= rsp_wp_in;
         rsp_last_ff   <= 1'b1;
      end
      if (cmd.emit) begin
         rsp_reads_ff  <= reads_ff;
         rsp_writes_ff <= writes_ff;
      end
      if (cmd.emit_blank) begin
         rsp_status_ff <= RS_OK;
         rsp_frame_ff  <= 3'd0;
         rsp_hit_ff    <= 1'b0;
         rsp_read_ff   <= 1'b0;
         rsp_wb_ff     <= 1'b0;
         rsp_wp_ff     <= '0;
         rsp_last_ff   <= 1'b1;
         rsp_reads_ff  <= reads_ff;
         rsp_writes_ff <= writes_ff;
      end
      if (cmd.flush_emit_step && emit_ok) begin
         rsp_status_ff <= RS_OK;
         rsp_frame_ff  <= idx3(ix_ff);
         rsp_hit_ff    <= 1'b0;
         rsp_read_ff   <= 1'b0;
         rsp_wb_ff     <= 1'b1;
         rsp_wp_ff     <= cur_page;
         rsp_last_ff   <= (fl_emit_ff == fl_cnt_ff - 1'b1);
         rsp_reads_ff  <= reads_ff;
         rsp_writes_ff <= writes_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_frame       = rsp_frame_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_page   = rsp_read_ff;
   assign rsp_write_back  = rsp_wb_ff;
   assign rsp_write_page  = rsp_wp_ff;
   assign rsp_reads_done  = rsp_reads_ff;
   assign rsp_writes_done = rsp_writes_ff;
   assign rsp_last        = rsp_last_ff;

   `BPR_ASSERT(a_hit_no_read, clock, reset, (rsp_valid_ff && rsp_hit_ff) |-> !rsp_read_ff, "hit word also asks for a read")
   `BPR_ASSERT_NEXT(a_flush_bound, clock, reset, cmd.flush_emit_step, fl_emit_ff <= fl_cnt_ff, "flush wrote more frames than counted")

endmodule

[src/buffer_pool_page_replacement.sv]
// Page buffer pool frame table with FIFO, LRU, CLOCK and LFU replacement.
// Request channel: start with req_opcode and req_page_number is taken at a
// clock edge where busy is low; busy stays high until the request is done.
// Config channel: csr_valid/csr_ready write the 2-bit policy from csr_data;
// csr_ready is always high. Write it only while the block is idle.
// Response channel: each word sits on rsp_* for one cycle with rsp_valid
// high; rsp_last marks the final word of a request. The receiver cannot
// stall, so words are never held back or dropped.
// Sequence: a lookup pass steps one frame per cycle over every frame, then
// a decide step, a victim pass for a pin that must replace a frame, an act
// step that updates the table and a done step that sends the word; the next
// request can be taken at the edge that ends that word. The victim pass
// scans every frame for LRU and LFU; FIFO stops at the first unpinned frame
// from its hand, CLOCK at the first unpinned one with its ref bit clear.
// Flush all counts the dirty unpinned frames in a pass over all frames, then
// steps one frame per cycle up to the last counted one, sending a word at each
// (up to 8) or one blank word if none, and the next request is taken at the
// edge that ends its last word. One request is in flight at a time.
// Reset: all frames empty, counters and hands zero, policy FIFO.
module buffer_pool_page_replacement import bpr_pkg::*; #(
   parameter int NUM_FRAMES = 8,
   parameter int PAGE_BITS  = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_opcode,
   input  logic [PAGE_BITS-1:0] req_page_number,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_data,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [2:0]           rsp_frame,
   output logic                 rsp_hit,
   output logic                 rsp_read_page,
   output logic                 rsp_write_back,
   output logic [PAGE_BITS-1:0] rsp_write_page,
   output logic [31:0]          rsp_reads_done,
   output logic [31:0]          rsp_writes_done,
   output logic                 rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   // policy writes are always taken
   assign csr_ready = 1'b1;

   // sequencer
   bpr_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // frame table and response word
   bpr_datapath #(
      .NUM_FRAMES (NUM_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_page_number (req_page_number),
      .csr_valid       (csr_valid),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_frame       (rsp_frame),
      .rsp_hit         (rsp_hit),
      .rsp_read_page   (rsp_read_page),
      .rsp_write_back  (rsp_write_back),
      .rsp_write_page  (rsp_write_page),
      .rsp_reads_done  (rsp_reads_done),
      .rsp_writes_done (rsp_writes_done),
      .rsp_last        (rsp_last)
   );

endmodule
